// File: rtl/core/sir_gillespie_event_step_macros.svh
`ifndef SIR_GILLESPIE_EVENT_STEP_MACROS_SVH
`define SIR_GILLESPIE_EVENT_STEP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SGE_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SGE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sge_pkg.sv
`default_nettype none

package sge_pkg;

    localparam int COUNT_BITS     = 16;
    localparam int LN_TABLE_DEPTH = 256;
    localparam int LN_BITS        = $clog2(LN_TABLE_DEPTH);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam int FRAC_W = 25;
    localparam int TIME_W = 40;
    localparam int LOG_W  = 31;

    localparam int DIV_NUM_W = 65;
    localparam int DIV_DEN_W = 50;
    localparam int DIV_LEN_W = $clog2(DIV_NUM_W + 1);

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [19:0] A_RESET    = 20'd6554;
    localparam logic [15:0] POP_RESET  = 16'd1000;
    localparam logic [15:0] END_RESET  = 16'd1000;
    localparam logic [15:0] WARM_RESET = 16'd100;

    localparam logic [FRAC_W-1:0] ONE_Q24   = 25'h1000000;
    localparam logic [FRAC_W-1:0] TENTH_Q24 = 25'd1677722;
    localparam logic [23:0]       LN2_Q24   = 24'd11629080;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_A_PARAM     = 2'd0,
        CFG_POP_SIZE    = 2'd1,
        CFG_END_TIME    = 2'd2,
        CFG_WARMUP_TIME = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_RESTART       = 3'd0,
        KIND_INFECTION     = 3'd1,
        KIND_RECOVERY      = 3'd2,
        KIND_IMMUNITY_LOSS = 3'd3,
        KIND_IGNORED       = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic                 go;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_LEN_W-1:0] len;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef logic [LOG_W-1:0] log_rom_t [LN_TABLE_DEPTH+1];

    // log2(1 + j/depth) in Q0.30 by repeated squaring
    function automatic logic [LOG_W-1:0] log2_entry(input int j);
        logic [63:0]      x;
        logic [LOG_W-1:0] r;
        x = (64'd1 << 30) + ((64'(j) << 30) / LN_TABLE_DEPTH);
        r = '0;
        for (int b = 29; b >= 0; b--)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic log_rom_t build_log_rom();
        log_rom_t t;
        for (int j = 0; j < LN_TABLE_DEPTH; j++)
        begin
            t[j] = log2_entry(j);
        end
        t[LN_TABLE_DEPTH] = LOG_W'(64'd1 << 30);
        return t;
    endfunction

    localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

`default_nettype wire

// File: rtl/core/sge_ifs.sv
`default_nettype none

interface sge_step_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] u_select;
    logic [31:0] u_time;

    modport source (output valid, output func, output u_select, output u_time, input ready);
    modport sink (input valid, input func, input u_select, input u_time, output ready);
endinterface

interface sge_result_if;
    logic        valid;
    logic        ready;
    logic [39:0] time_now;
    logic [15:0] s_count;
    logic [15:0] i_count;
    logic [15:0] r_count;
    logic [2:0]  event_kind;
    logic [31:0] avg_s;
    logic [31:0] avg_i;
    logic        run_done;

    modport source (output valid, output time_now, output s_count, output i_count,
                    output r_count, output event_kind, output avg_s, output avg_i,
                    output run_done, input ready);
    modport sink (input valid, input time_now, input s_count, input i_count,
                  input r_count, input event_kind, input avg_s, input avg_i,
                  input run_done, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sge_div.sv
`default_nettype none

module sge_div import sge_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_LEN_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DIV_NUM_W-1]};
        trial     = shifted - {1'b0, req.den};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            quot_next = req.num;
            rem_next  = '0;
            cnt_next  = req.len;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, req.den})
            begin
                rem_next  = trial[DIV_DEN_W-1:0];
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DIV_DEN_W-1:0];
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_LEN_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

// File: rtl/core/sge_mul.sv
`default_nettype none

module sge_mul import sge_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] p
);

    logic [MUL_P_W-1:0] p_reg, p_next;

    always_comb
    begin
        p_next = en ? (MUL_P_W'(a) * MUL_P_W'(b)) : p_reg;
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: rtl/core/sir_gillespie_event_step.sv
// One Gillespie event of an SIR model with reinfection per request: a step moves one count
// between S, I and R and advances time by -ln(u_time)/(total rate * N), and a restart sets
// S = N/2, I = N - S, R = 0 with time and averages cleared. A full step is paced by the
// one-bit-per-cycle divider that serves the three fractions, the rate ratio, the time
// increment and, after warmup, both average updates; a small u_time is first normalized by
// shifting. A multiplier registered at its output serves the other products, while the
// multiples of fs and fi by small constants are built from shifts and adds. The request
// channel is taken only between steps; a finished result waits in an output register while
// the next request is accepted.
`default_nettype none

`include "sir_gillespie_event_step_macros.svh"

module sir_gillespie_event_step import sge_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sge_step_if.sink               step,
    sge_result_if.source           result
);

    typedef enum logic [23:0] {
        ST_IDLE    = 24'h000001,
        ST_FRAC    = 24'h000002,
        ST_RATIO   = 24'h000004,
        ST_M_R1    = 24'h000008,
        ST_M_R3    = 24'h000010,
        ST_TOTAL   = 24'h000020,
        ST_V_HI    = 24'h000040,
        ST_V_LO    = 24'h000080,
        ST_TN      = 24'h000100,
        ST_LN_NORM = 24'h000200,
        ST_LN_ROM  = 24'h000400,
        ST_LN_D    = 24'h000800,
        ST_LN_LG   = 24'h001000,
        ST_LN_NL   = 24'h002000,
        ST_LN_CAP  = 24'h004000,
        ST_DT      = 24'h008000,
        ST_TIME    = 24'h010000,
        ST_WARM    = 24'h020000,
        ST_SUM_LO  = 24'h040000,
        ST_SUM_HI  = 24'h080000,
        ST_SUM_CAT = 24'h100000,
        ST_SUM_DIV = 24'h200000,
        ST_MOVE    = 24'h400000,
        ST_FINISH  = 24'h800000
    } state_t;

    localparam int FRAC_LEN  = COUNT_BITS + 24;
    localparam int RATIO_LEN = 52;
    localparam int DT_LEN    = 53;

    typedef logic [COUNT_BITS-1:0] count_t;

    function automatic count_t dec_sat(input count_t c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    function automatic count_t inc_sat(input count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [TIME_W-1:0] add_sat40(input logic [TIME_W-1:0] a,
                                                    input logic [48:0] b);
        logic [49:0] s;
        s = 50'(a) + 50'(b);
        return (|s[49:TIME_W]) ? '1 : s[TIME_W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [19:0] a_reg, a_next;
    logic [15:0] pop_reg, pop_next;
    logic [15:0] end_reg, end_next;
    logic [15:0] warm_reg, warm_next;

    count_t            sus_reg, sus_next, inf_reg, inf_next, rec_reg, rec_next;
    logic [TIME_W-1:0] sim_time_reg, sim_time_next;
    logic [TIME_W-1:0] sum_s_reg, sum_s_next, sum_i_reg, sum_i_next;
    logic              finished_reg, finished_next;

    logic [1:0] frac_sel_reg, frac_sel_next;
    logic       div_started_reg, div_started_next;
    logic       sel_i_reg, sel_i_next;

    logic [31:0]          us_reg, us_next;
    logic [31:0]          m_reg, m_next;
    logic [5:0]           k_reg, k_next;
    logic [FRAC_W-1:0]    fs_reg, fs_next, fi_reg, fi_next, fr_reg, fr_next;
    logic [31:0]          ratio_reg, ratio_next;
    logic [31:0]          r1_reg, r1_next;
    logic [32:0]          total_reg, total_next;
    logic [48:0]          vhi_reg, vhi_next;
    logic [33:0]          v_reg, v_next;
    logic [DIV_DEN_W-1:0] tn_reg, tn_next;
    logic [LOG_W-1:0]     t0_reg, t0_next, d_reg, d_next;
    logic [35:0]          nl2_reg, nl2_next;
    logic [28:0]          neglog_reg, neglog_next;
    logic [TIME_W-1:0]    dt_reg, dt_next;
    logic [44:0]          plo_reg, plo_next;
    logic [DIV_NUM_W-1:0] prod_reg, prod_next;
    event_kind_t          kind_reg, kind_next;

    logic        out_valid_reg, out_valid_next;
    logic [39:0] o_time_reg, o_time_next;
    logic [15:0] o_s_reg, o_s_next, o_i_reg, o_i_next, o_r_reg, o_r_next;
    logic [2:0]  o_kind_reg, o_kind_next;
    logic [31:0] o_avg_s_reg, o_avg_s_next, o_avg_i_reg, o_avg_i_next;
    logic        o_done_reg, o_done_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic [15:0]       n_eff;
    logic [15:0]       span;
    logic [TIME_W-1:0] end_q;
    logic [TIME_W-1:0] warm_q;
    logic [28:0]       den_ratio;
    logic [27:0]       ten_fi;
    logic [26:0]       r2;
    logic [32:0]       r12;
    logic [FRAC_W-1:0] frac_pick;
    count_t            cnt_pick;
    logic [LN_BITS-1:0] ln_idx;
    logic [LOG_W-1:0]  rom_t0, rom_t1;
    logic [LOG_W-1:0]  ln_rem;
    logic [31:0]       lg;
    logic [40:0]       time_sum;
    logic              ratio_skip;
    logic              div_state;
    logic              out_load;

    sge_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    sge_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_comb
    begin
        n_eff     = (pop_reg == '0) ? 16'd1 : pop_reg;
        span      = (end_reg > warm_reg) ? (end_reg - warm_reg) : 16'd1;
        end_q     = {end_reg, 24'b0};
        warm_q    = {warm_reg, 24'b0};
        den_ratio = {1'b0, a_reg, 8'b0} + 29'(fs_reg);
        ten_fi    = 28'({fi_reg, 3'b0}) + 28'({fi_reg, 1'b0});
        r2        = 27'({fi_reg, 2'b0}) + 27'(fi_reg);
        r12       = 33'(r1_reg) + 33'(r2);
        frac_pick = sel_i_reg ? fi_reg : fs_reg;
        unique case (frac_sel_reg)
            2'd0:    cnt_pick = sus_reg;
            2'd1:    cnt_pick = inf_reg;
            default: cnt_pick = rec_reg;
        endcase
        ln_idx     = m_reg[30 -: LN_BITS];
        rom_t0     = LOG_ROM[{1'b0, ln_idx}];
        rom_t1     = LOG_ROM[{1'b0, ln_idx} + 1'b1];
        ln_rem     = {m_reg[30-LN_BITS:0], LN_BITS'(0)};
        lg         = 32'(t0_reg) + 32'(mul_p[61:31]);
        time_sum   = 41'(sim_time_reg) + 41'(dt_reg);
        ratio_skip = (state_reg == ST_RATIO) && (den_ratio == '0);
        div_state  = (state_reg == ST_FRAC) || (state_reg == ST_RATIO) ||
                     (state_reg == ST_DT) || (state_reg == ST_SUM_DIV);
        out_load   = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);
    end

    always_comb
    begin
        div_req.go  = div_state && !div_started_reg && !ratio_skip;
        div_req.num = '0;
        div_req.den = DIV_DEN_W'(1);
        div_req.len = DIV_LEN_W'(FRAC_LEN);
        unique case (state_reg)
            ST_FRAC:
            begin
                div_req.num = DIV_NUM_W'({cnt_pick, 24'b0}) << (DIV_NUM_W - FRAC_LEN);
                div_req.den = DIV_DEN_W'(n_eff);
                div_req.len = DIV_LEN_W'(FRAC_LEN);
            end
            ST_RATIO:
            begin
                div_req.num = DIV_NUM_W'({ten_fi, 24'b0}) << (DIV_NUM_W - RATIO_LEN);
                div_req.den = DIV_DEN_W'(den_ratio);
                div_req.len = DIV_LEN_W'(RATIO_LEN);
            end
            ST_DT:
            begin
                div_req.num = DIV_NUM_W'({neglog_reg, 24'b0}) << (DIV_NUM_W - DT_LEN);
                div_req.den = tn_reg;
                div_req.len = DIV_LEN_W'(DT_LEN);
            end
            ST_SUM_DIV:
            begin
                div_req.num = prod_reg;
                div_req.den = DIV_DEN_W'(span);
                div_req.len = DIV_LEN_W'(DIV_NUM_W);
            end
            default:
            begin
                div_req.num = '0;
            end
        endcase
    end

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_M_R1:
            begin
                mul_a = MUL_A_W'(33'(ratio_reg) + 33'(ONE_Q24));
                mul_b = MUL_B_W'(fs_reg);
            end
            ST_M_R3:
            begin
                mul_a = MUL_A_W'(29'({fs_reg, 3'b0}) + 29'({fs_reg, 1'b0}) + 29'(TENTH_Q24));
                mul_b = MUL_B_W'(fr_reg);
            end
            ST_V_HI:
            begin
                mul_a = MUL_A_W'(us_reg);
                mul_b = MUL_B_W'(total_reg[32:16]);
            end
            ST_V_LO:
            begin
                mul_a = MUL_A_W'(us_reg);
                mul_b = MUL_B_W'(total_reg[15:0]);
            end
            ST_TN:
            begin
                mul_a = MUL_A_W'(total_reg);
                mul_b = MUL_B_W'(n_eff);
            end
            ST_LN_D:
            begin
                mul_a = MUL_A_W'(d_reg);
                mul_b = MUL_B_W'(ln_rem);
            end
            ST_LN_NL:
            begin
                mul_a = nl2_reg;
                mul_b = MUL_B_W'(LN2_Q24);
            end
            ST_SUM_LO:
            begin
                mul_a = MUL_A_W'(dt_reg[19:0]);
                mul_b = MUL_B_W'(frac_pick);
            end
            ST_SUM_HI:
            begin
                mul_a = MUL_A_W'(dt_reg[39:20]);
                mul_b = MUL_B_W'(frac_pick);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        a_next           = a_reg;
        pop_next         = pop_reg;
        end_next         = end_reg;
        warm_next        = warm_reg;
        sus_next         = sus_reg;
        inf_next         = inf_reg;
        rec_next         = rec_reg;
        sim_time_next    = sim_time_reg;
        sum_s_next       = sum_s_reg;
        sum_i_next       = sum_i_reg;
        finished_next    = finished_reg;
        frac_sel_next    = frac_sel_reg;
        div_started_next = div_started_reg;
        sel_i_next       = sel_i_reg;
        us_next          = us_reg;
        m_next           = m_reg;
        k_next           = k_reg;
        fs_next          = fs_reg;
        fi_next          = fi_reg;
        fr_next          = fr_reg;
        ratio_next       = ratio_reg;
        r1_next          = r1_reg;
        total_next       = total_reg;
        vhi_next         = vhi_reg;
        v_next           = v_reg;
        tn_next          = tn_reg;
        t0_next          = t0_reg;
        d_next           = d_reg;
        nl2_next         = nl2_reg;
        neglog_next      = neglog_reg;
        dt_next          = dt_reg;
        plo_next         = plo_reg;
        prod_next        = prod_reg;
        kind_next        = kind_reg;
        out_valid_next   = out_valid_reg;
        o_time_next      = o_time_reg;
        o_s_next         = o_s_reg;
        o_i_next         = o_i_reg;
        o_r_next         = o_r_reg;
        o_kind_next      = o_kind_reg;
        o_avg_s_next     = o_avg_s_reg;
        o_avg_i_next     = o_avg_i_reg;
        o_done_next      = o_done_reg;

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_A_PARAM:     a_next    = cfg_data;
                CFG_POP_SIZE:    pop_next  = cfg_data[15:0];
                CFG_END_TIME:    end_next  = cfg_data[15:0];
                CFG_WARMUP_TIME: warm_next = cfg_data[15:0];
            endcase
        end

        if (div_req.go)
        begin
            div_started_next = 1'b1;
        end
        if (div_rsp.done)
        begin
            div_started_next = 1'b0;
        end

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (step.valid)
                begin
                    us_next       = step.u_select;
                    m_next        = step.u_time;
                    k_next        = 6'd1;
                    frac_sel_next = 2'd0;
                    sel_i_next    = 1'b0;
                    state_next    = ST_FINISH;
                    if (step.func)
                    begin
                        sus_next      = COUNT_BITS'(pop_reg >> 1);
                        inf_next      = COUNT_BITS'(pop_reg - (pop_reg >> 1));
                        rec_next      = '0;
                        sim_time_next = '0;
                        sum_s_next    = '0;
                        sum_i_next    = '0;
                        kind_next     = KIND_RESTART;
                    end
                    else if (finished_reg || (sim_time_reg >= end_q))
                    begin
                        kind_next = KIND_IGNORED;
                    end
                    else
                    begin
                        state_next = ST_FRAC;
                    end
                end
            end
            ST_FRAC:
            begin
                if (div_rsp.done)
                begin
                    unique case (frac_sel_reg)
                        2'd0:    fs_next = (div_rsp.quot > DIV_NUM_W'(ONE_Q24)) ?
                                           ONE_Q24 : div_rsp.quot[FRAC_W-1:0];
                        2'd1:    fi_next = (div_rsp.quot > DIV_NUM_W'(ONE_Q24)) ?
                                           ONE_Q24 : div_rsp.quot[FRAC_W-1:0];
                        default: fr_next = (div_rsp.quot > DIV_NUM_W'(ONE_Q24)) ?
                                           ONE_Q24 : div_rsp.quot[FRAC_W-1:0];
                    endcase
                    if (frac_sel_reg == 2'd2)
                    begin
                        state_next = ST_RATIO;
                    end
                    else
                    begin
                        frac_sel_next = frac_sel_reg + 1'b1;
                    end
                end
            end
            ST_RATIO:
            begin
                if (ratio_skip)
                begin
                    ratio_next = '0;
                    state_next = ST_M_R1;
                end
                else if (div_rsp.done)
                begin
                    ratio_next = (|div_rsp.quot[DIV_NUM_W-1:32]) ? '1 : div_rsp.quot[31:0];
                    state_next = ST_M_R1;
                end
            end
            ST_M_R1:
            begin
                state_next = ST_M_R3;
            end
            ST_M_R3:
            begin
                r1_next    = (|mul_p[MUL_P_W-1:56]) ? '1 : mul_p[55:24];
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                total_next = r12 + 33'(mul_p[51:24]);
                state_next = ST_V_HI;
            end
            ST_V_HI:
            begin
                if (total_reg == '0)
                begin
                    kind_next  = KIND_IGNORED;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_V_LO;
                end
            end
            ST_V_LO:
            begin
                vhi_next   = mul_p[48:0];
                state_next = ST_TN;
            end
            ST_TN:
            begin
                v_next     = 34'((50'(vhi_reg) + 50'(mul_p[47:16])) >> 16);
                state_next = ST_LN_NORM;
            end
            ST_LN_NORM:
            begin
                tn_next = mul_p[DIV_DEN_W-1:0];
                if (m_reg == '0)
                begin
                    neglog_next = '0;
                    state_next  = ST_DT;
                end
                else if (m_reg[31])
                begin
                    state_next = ST_LN_ROM;
                end
                else
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    k_next = k_reg + 1'b1;
                end
            end
            ST_LN_ROM:
            begin
                t0_next    = rom_t0;
                d_next     = (rom_t1 >= rom_t0) ? (rom_t1 - rom_t0) : '0;
                state_next = ST_LN_D;
            end
            ST_LN_D:
            begin
                state_next = ST_LN_LG;
            end
            ST_LN_LG:
            begin
                nl2_next   = 36'({k_reg, 30'b0}) - 36'(lg);
                state_next = ST_LN_NL;
            end
            ST_LN_NL:
            begin
                state_next = ST_LN_CAP;
            end
            ST_LN_CAP:
            begin
                neglog_next = mul_p[58:30];
                state_next  = ST_DT;
            end
            ST_DT:
            begin
                if (div_rsp.done)
                begin
                    dt_next    = (|div_rsp.quot[DIV_NUM_W-1:TIME_W]) ?
                                 '1 : div_rsp.quot[TIME_W-1:0];
                    state_next = ST_TIME;
                end
            end
            ST_TIME:
            begin
                sim_time_next = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
                state_next    = ST_WARM;
            end
            ST_WARM:
            begin
                state_next = (sim_time_reg >= warm_q) ? ST_SUM_LO : ST_MOVE;
            end
            ST_SUM_LO:
            begin
                state_next = ST_SUM_HI;
            end
            ST_SUM_HI:
            begin
                plo_next   = mul_p[44:0];
                state_next = ST_SUM_CAT;
            end
            ST_SUM_CAT:
            begin
                prod_next  = DIV_NUM_W'({mul_p[44:0], 20'b0}) + DIV_NUM_W'(plo_reg);
                state_next = ST_SUM_DIV;
            end
            ST_SUM_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (sel_i_reg)
                    begin
                        sum_i_next = add_sat40(sum_i_reg, div_rsp.quot[DIV_NUM_W-1:16]);
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        sum_s_next = add_sat40(sum_s_reg, div_rsp.quot[DIV_NUM_W-1:16]);
                        sel_i_next = 1'b1;
                        state_next = ST_SUM_LO;
                    end
                end
            end
            ST_MOVE:
            begin
                priority if (v_reg < 34'(r1_reg))
                begin
                    sus_next  = dec_sat(sus_reg);
                    inf_next  = inc_sat(inf_reg);
                    kind_next = KIND_INFECTION;
                end
                else if (v_reg < 34'(r12))
                begin
                    inf_next  = dec_sat(inf_reg);
                    rec_next  = inc_sat(rec_reg);
                    kind_next = KIND_RECOVERY;
                end
                else
                begin
                    rec_next  = dec_sat(rec_reg);
                    sus_next  = inc_sat(sus_reg);
                    kind_next = KIND_IMMUNITY_LOSS;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    finished_next  = (sim_time_reg >= end_q);
                    out_valid_next = 1'b1;
                    o_time_next    = sim_time_reg;
                    o_s_next       = 16'(sus_reg);
                    o_i_next       = 16'(inf_reg);
                    o_r_next       = 16'(rec_reg);
                    o_kind_next    = kind_reg;
                    o_avg_s_next   = (|sum_s_reg[39:32]) ? '1 : sum_s_reg[31:0];
                    o_avg_i_next   = (|sum_i_reg[39:32]) ? '1 : sum_i_reg[31:0];
                    o_done_next    = (sim_time_reg >= end_q);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            a_reg           <= A_RESET;
            pop_reg         <= POP_RESET;
            end_reg         <= END_RESET;
            warm_reg        <= WARM_RESET;
            sus_reg         <= COUNT_BITS'(POP_RESET >> 1);
            inf_reg         <= COUNT_BITS'(POP_RESET - (POP_RESET >> 1));
            rec_reg         <= '0;
            sim_time_reg    <= '0;
            sum_s_reg       <= '0;
            sum_i_reg       <= '0;
            finished_reg    <= 1'b0;
            frac_sel_reg    <= 2'd0;
            div_started_reg <= 1'b0;
            sel_i_reg       <= 1'b0;
            kind_reg        <= KIND_RESTART;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            a_reg           <= a_next;
            pop_reg         <= pop_next;
            end_reg         <= end_next;
            warm_reg        <= warm_next;
            sus_reg         <= sus_next;
            inf_reg         <= inf_next;
            rec_reg         <= rec_next;
            sim_time_reg    <= sim_time_next;
            sum_s_reg       <= sum_s_next;
            sum_i_reg       <= sum_i_next;
            finished_reg    <= finished_next;
            frac_sel_reg    <= frac_sel_next;
            div_started_reg <= div_started_next;
            sel_i_reg       <= sel_i_next;
            kind_reg        <= kind_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        us_reg      <= us_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        fs_reg      <= fs_next;
        fi_reg      <= fi_next;
        fr_reg      <= fr_next;
        ratio_reg   <= ratio_next;
        r1_reg      <= r1_next;
        total_reg   <= total_next;
        vhi_reg     <= vhi_next;
        v_reg       <= v_next;
        tn_reg      <= tn_next;
        t0_reg      <= t0_next;
        d_reg       <= d_next;
        nl2_reg     <= nl2_next;
        neglog_reg  <= neglog_next;
        dt_reg      <= dt_next;
        plo_reg     <= plo_next;
        prod_reg    <= prod_next;
        o_time_reg  <= o_time_next;
        o_s_reg     <= o_s_next;
        o_i_reg     <= o_i_next;
        o_r_reg     <= o_r_next;
        o_kind_reg  <= o_kind_next;
        o_avg_s_reg <= o_avg_s_next;
        o_avg_i_reg <= o_avg_i_next;
        o_done_reg  <= o_done_next;
    end

    assign step.ready        = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.time_now   = o_time_reg;
    assign result.s_count    = o_s_reg;
    assign result.i_count    = o_i_reg;
    assign result.r_count    = o_r_reg;
    assign result.event_kind = o_kind_reg;
    assign result.avg_s      = o_avg_s_reg;
    assign result.avg_i      = o_avg_i_reg;
    assign result.run_done   = o_done_reg;

    `SGE_ASSERT_IMPLIES(a_div_go_free, div_req.go, !div_rsp.busy, "divider started while busy")
    `SGE_ASSERT_NEXT(a_time_grows, state_reg == ST_TIME, sim_time_reg >= $past(sim_time_reg), "time went backward on a step")
    `SGE_ASSERT_NEXT(a_done_flag, out_load, result.run_done == (result.time_now >= {end_reg, 24'b0}), "run_done does not match time")

endmodule

`default_nettype wire
